// ----- hdl/i2c_master_bit_engine_macros.svh -----
// Assertion macros shared by the I2C master bit engine RTL.
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define I2C_MBE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define I2C_MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/i2c_mbe_pkg.sv -----
// Types and constants for the I2C master bit engine.
package i2c_mbe_pkg;

  // Default queue depths
  localparam int TX_DEPTH_DEF = 16;
  localparam int RX_DEPTH_DEF = 16;

  // Request kinds carried in in_tuser
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_PUSH  = 2'd1,
    REQ_START = 2'd2,
    REQ_POP   = 2'd3
  } req_t;

  // Bus sequencer states
  typedef enum logic [2:0] {
    BS_START = 3'd0,
    BS_DOUT  = 3'd1,
    BS_RACK  = 3'd2,
    BS_DIN   = 3'd3,
    BS_GACK  = 3'd4,
    BS_STOP  = 3'd5
  } bus_state_t;

  // Status codes
  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_BUSY = 2'd1,
    STS_ERR  = 2'd2
  } status_t;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam int         IN_DATA_W     = 40;
  localparam int         OUT_DATA_W    = 24;
  localparam int         RX_LEVEL_W    = 5;

  // Result item, lowest field last
  typedef struct packed {
    logic [3:0]            pad;
    logic [RX_LEVEL_W-1:0] rx_level;
    logic                  rx_valid;
    logic [7:0]            rx_byte;
    logic                  done_res;
    logic [1:0]            status;
    logic                  busy_res;
    logic                  sda_out;
    logic                  scl_out;
  } out_item_t;

endpackage

// ----- hdl/i2c_master_bit_engine.sv -----
// I2C master bit engine: tick-driven bus sequencer with TX/RX byte queues.
//
//  Channel  | Dir | Ports                      | Payload
//  ---------+-----+----------------------------+-----------------------------------
//  request  | in  | in_tvalid/in_tready        | tuser: req_type; tdata: sda_in,
//           |     | in_tuser, in_tdata         |   data_byte, slave_addr, receive_count
//  result   | out | out_tvalid/out_tready      | tdata: scl, sda, busy, status, done,
//           |     | out_tdata                  |   rx_byte, rx_valid, rx_level
//
// The bus state, queues and result are all updated in the accepting cycle, and
// the result lands in the output register, or in the skid while that is held.
// While a transaction is active, each tick request is one half period of SCL.
// A two-entry output buffer (output register plus skid) keeps in_tready high
// while one result waits; only a full buffer stalls the request side.
// Synchronous active-low reset: queues empty, sequencer at start, lines high.
`include "i2c_master_bit_engine_macros.svh"

module i2c_master_bit_engine #(
  parameter int TX_DEPTH = i2c_mbe_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = i2c_mbe_pkg::RX_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [1:0]                         in_tuser,   // [1:0] req_type
  // [0] sda_in, [8:1] data_byte, [16:9] slave_addr, [32:17] receive_count
  input  logic [i2c_mbe_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [4:3] status, [5] done_res,
  // [13:6] rx_byte, [14] rx_valid, [19:15] rx_level
  output logic [i2c_mbe_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int TX_PW = $clog2(TX_DEPTH);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int RX_PW = $clog2(RX_DEPTH);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int RX_LW = i2c_mbe_pkg::RX_LEVEL_W;

  // Request fields
  i2c_mbe_pkg::req_t req;
  logic              f_sda;
  logic [7:0]        f_data;
  logic [7:0]        f_arw;
  logic [15:0]       f_cnt;
  logic              accept;

  assign req    = i2c_mbe_pkg::req_t'(in_tuser);
  assign f_sda  = in_tdata[0];
  assign f_data = in_tdata[8:1];
  assign f_arw  = in_tdata[16:9];
  assign f_cnt  = in_tdata[32:17];

  // Sequencer state
  logic                    phase_r, phase_nxt;
  i2c_mbe_pkg::bus_state_t bus_r, bus_nxt;
  logic [7:0]              shift_r, shift_nxt;
  logic [3:0]              bit_r, bit_nxt;
  logic [7:0]              arw_r, arw_nxt;
  logic [15:0]             left_r, left_nxt;
  i2c_mbe_pkg::status_t    sts_r, sts_nxt;
  logic                    active_r, active_nxt;
  logic                    scl_r, scl_nxt;
  logic                    sda_r, sda_nxt;

  // Queue state
  logic [7:0]       tx_mem [TX_DEPTH];
  logic [7:0]       rx_mem [RX_DEPTH];
  logic [TX_PW-1:0] tx_rd_r, tx_rd_nxt, tx_wr_r, tx_wr_nxt;
  logic [TX_CW-1:0] tx_cnt_r, tx_cnt_nxt;
  logic [RX_PW-1:0] rx_rd_r, rx_rd_nxt, rx_wr_r, rx_wr_nxt;
  logic [RX_CW-1:0] rx_cnt_r, rx_cnt_nxt;
  logic [7:0]       tx_head_r, rx_head_r;
  logic             tx_we, tx_pop, rx_we, rx_pop;
  logic [7:0]       rx_wdata;

  // Result bits from this request
  logic        done;
  logic [7:0]  pop_byte;
  logic        pop_valid;
  logic [7:0]  din_shift;
  logic [3:0]  bit_inc;
  logic [15:0] left_dec;

  // Output buffer
  i2c_mbe_pkg::out_item_t res, out_data_r, skid_data_r;
  logic                   out_valid_r, skid_valid_r;

  assign in_tready  = !skid_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign bit_inc   = bit_r + 4'd1;
  assign din_shift = {shift_r[6:0], f_sda};
  assign left_dec  = (left_r != 16'd0) ? left_r - 16'd1 : left_r;

  // Next state for the accepted request
  always_comb begin
    phase_nxt  = phase_r;
    bus_nxt    = bus_r;
    shift_nxt  = shift_r;
    bit_nxt    = bit_r;
    arw_nxt    = arw_r;
    left_nxt   = left_r;
    sts_nxt    = sts_r;
    active_nxt = active_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    tx_we      = 1'b0;
    tx_pop     = 1'b0;
    rx_we      = 1'b0;
    rx_pop     = 1'b0;
    rx_wdata   = din_shift;
    done       = 1'b0;
    pop_byte   = 8'd0;
    pop_valid  = 1'b0;
    if (accept) begin
      unique case (req)
        i2c_mbe_pkg::REQ_TICK: begin
          if (active_r && !phase_r) begin
            // high phase: start, sample, stop
            phase_nxt = 1'b1;
            scl_nxt   = 1'b1;
            unique case (bus_r)
              i2c_mbe_pkg::BS_START: begin
                sda_nxt   = 1'b0;
                shift_nxt = arw_r;
                bus_nxt   = i2c_mbe_pkg::BS_DOUT;
                bit_nxt   = 4'd0;
              end
              i2c_mbe_pkg::BS_DOUT: begin
                if (bit_r == i2c_mbe_pkg::BITS_PER_BYTE) begin
                  bit_nxt   = 4'd0;
                  shift_nxt = 8'd0;
                  bus_nxt   = i2c_mbe_pkg::BS_RACK;
                end
              end
              i2c_mbe_pkg::BS_RACK: begin
                if (!f_sda) begin
                  if (arw_r[0]) begin
                    bus_nxt = i2c_mbe_pkg::BS_DIN;
                  end else if (tx_cnt_r != '0) begin
                    bus_nxt   = i2c_mbe_pkg::BS_DOUT;
                    shift_nxt = tx_head_r;
                    tx_pop    = 1'b1;
                  end else begin
                    bus_nxt = i2c_mbe_pkg::BS_STOP;
                  end
                end else begin
                  bus_nxt = i2c_mbe_pkg::BS_STOP;
                  sts_nxt = i2c_mbe_pkg::STS_ERR;
                end
              end
              i2c_mbe_pkg::BS_DIN: begin
                shift_nxt = din_shift;
                bit_nxt   = bit_inc;
                if (bit_inc == i2c_mbe_pkg::BITS_PER_BYTE) begin
                  bit_nxt   = 4'd0;
                  rx_we     = (rx_cnt_r < RX_CW'(RX_DEPTH));
                  shift_nxt = 8'd0;
                  left_nxt  = left_dec;
                  bus_nxt   = (left_dec == 16'd0) ? i2c_mbe_pkg::BS_STOP
                                                  : i2c_mbe_pkg::BS_GACK;
                end
              end
              i2c_mbe_pkg::BS_GACK: begin
                bus_nxt = i2c_mbe_pkg::BS_DIN;
              end
              i2c_mbe_pkg::BS_STOP: begin
                sda_nxt    = 1'b1;
                active_nxt = 1'b0;
                bus_nxt    = i2c_mbe_pkg::BS_START;
                phase_nxt  = 1'b0;
                if (sts_r != i2c_mbe_pkg::STS_ERR) begin
                  sts_nxt = i2c_mbe_pkg::STS_OK;
                end
                done = 1'b1;
              end
              default: begin
              end
            endcase
          end else if (active_r) begin
            // low phase: drive SDA
            phase_nxt = 1'b0;
            scl_nxt   = 1'b0;
            unique case (bus_r) inside
              i2c_mbe_pkg::BS_DOUT: begin
                sda_nxt   = shift_r[7];
                shift_nxt = {shift_r[6:0], 1'b0};
                bit_nxt   = bit_inc;
              end
              i2c_mbe_pkg::BS_RACK, i2c_mbe_pkg::BS_DIN: sda_nxt = 1'b1;
              i2c_mbe_pkg::BS_GACK, i2c_mbe_pkg::BS_STOP: sda_nxt = 1'b0;
              default: begin
              end
            endcase
          end
        end
        i2c_mbe_pkg::REQ_PUSH: begin
          tx_we = (tx_cnt_r < TX_CW'(TX_DEPTH));
        end
        i2c_mbe_pkg::REQ_START: begin
          if (!active_r) begin
            arw_nxt    = f_arw;
            left_nxt   = (f_cnt == 16'd0) ? 16'd1 : f_cnt;
            bit_nxt    = 4'd0;
            shift_nxt  = 8'd0;
            bus_nxt    = i2c_mbe_pkg::BS_START;
            sts_nxt    = i2c_mbe_pkg::STS_BUSY;
            active_nxt = 1'b1;
          end
        end
        i2c_mbe_pkg::REQ_POP: begin
          if (rx_cnt_r != '0) begin
            rx_pop    = 1'b1;
            pop_byte  = rx_head_r;
            pop_valid = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Queue pointers, wrapping at the depth
  always_comb begin
    tx_wr_nxt  = tx_wr_r;
    tx_rd_nxt  = tx_rd_r;
    tx_cnt_nxt = tx_cnt_r;
    rx_wr_nxt  = rx_wr_r;
    rx_rd_nxt  = rx_rd_r;
    rx_cnt_nxt = rx_cnt_r;
    if (tx_we) begin
      tx_wr_nxt  = (tx_wr_r == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_wr_r + 1'b1;
      tx_cnt_nxt = tx_cnt_r + 1'b1;
    end
    if (tx_pop) begin
      tx_rd_nxt  = (tx_rd_r == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_rd_r + 1'b1;
      tx_cnt_nxt = tx_cnt_r - 1'b1;
    end
    if (rx_we) begin
      rx_wr_nxt  = (rx_wr_r == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_wr_r + 1'b1;
      rx_cnt_nxt = rx_cnt_r + 1'b1;
    end
    if (rx_pop) begin
      rx_rd_nxt  = (rx_rd_r == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_rd_r + 1'b1;
      rx_cnt_nxt = rx_cnt_r - 1'b1;
    end
  end

  // Queue storage; head registers track the next read pointer, with write bypass
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wr_r] <= f_data;
    end
    if (rx_we) begin
      rx_mem[rx_wr_r] <= rx_wdata;
    end
    tx_head_r <= (tx_we && tx_wr_r == tx_rd_nxt) ? f_data : tx_mem[tx_rd_nxt];
    rx_head_r <= (rx_we && rx_wr_r == rx_rd_nxt) ? rx_wdata : rx_mem[rx_rd_nxt];
  end

  // Result item
  always_comb begin
    res          = '0;
    res.scl_out  = scl_nxt;
    res.sda_out  = sda_nxt;
    res.busy_res = active_nxt;
    res.status   = sts_nxt;
    res.done_res = done;
    res.rx_byte  = pop_byte;
    res.rx_valid = pop_valid;
    res.rx_level = RX_LW'(rx_cnt_nxt);
  end

  // Control and sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      bus_r    <= i2c_mbe_pkg::BS_START;
      shift_r  <= 8'd0;
      bit_r    <= 4'd0;
      arw_r    <= 8'd0;
      left_r   <= 16'd0;
      sts_r    <= i2c_mbe_pkg::STS_OK;
      active_r <= 1'b0;
      scl_r    <= 1'b1;
      sda_r    <= 1'b1;
      tx_rd_r  <= '0;
      tx_wr_r  <= '0;
      tx_cnt_r <= '0;
      rx_rd_r  <= '0;
      rx_wr_r  <= '0;
      rx_cnt_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      bus_r    <= bus_nxt;
      shift_r  <= shift_nxt;
      bit_r    <= bit_nxt;
      arw_r    <= arw_nxt;
      left_r   <= left_nxt;
      sts_r    <= sts_nxt;
      active_r <= active_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
      tx_rd_r  <= tx_rd_nxt;
      tx_wr_r  <= tx_wr_nxt;
      tx_cnt_r <= tx_cnt_nxt;
      rx_rd_r  <= rx_rd_nxt;
      rx_wr_r  <= rx_wr_nxt;
      rx_cnt_r <= rx_cnt_nxt;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept) begin
        out_data_r <= res;
      end
    end else if (accept) begin
      skid_data_r <= res;
    end
  end

  // Checks
  `I2C_MBE_ASSERT_IMPL(a_tx_bound, 1'b1, tx_cnt_r <= TX_CW'(TX_DEPTH), "tx count over depth")
  `I2C_MBE_ASSERT_IMPL(a_rx_bound, 1'b1, rx_cnt_r <= RX_CW'(RX_DEPTH), "rx count over depth")
  `I2C_MBE_ASSERT_IMPL(a_skid_order, skid_valid_r, out_valid_r, "skid holds data ahead of output")
  `I2C_MBE_ASSERT_IMPL(a_done_idle, out_valid_r && out_data_r.done_res, !out_data_r.busy_res, "done while busy")
  `I2C_MBE_ASSERT_IMPL(a_end_at_stop, $fell(active_r), $past(bus_r) == i2c_mbe_pkg::BS_STOP, "transaction ended outside stop")
  `I2C_MBE_ASSERT_NEXT(a_skid_drain, skid_valid_r && out_tready, !skid_valid_r, "skid not drained")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the I2C master bit engine, built on a bus predictor.
`timescale 1ns / 100ps

module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [1:0]                         in_tuser = i2c_mbe_pkg::REQ_TICK;  // [1:0] req_type
  // [0] sda_in, [8:1] data_byte, [16:9] slave_addr, [32:17] receive_count
  logic [i2c_mbe_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  // [0] scl_out, [1] sda_out, [2] busy_res, [4:3] status, [5] done_res,
  // [13:6] rx_byte, [14] rx_valid, [19:15] rx_level
  logic [i2c_mbe_pkg::OUT_DATA_W-1:0] out_tdata;

  i2c_master_bit_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted bus engine state
  bit                      clk_phase = 1'b0;
  i2c_mbe_pkg::bus_state_t seq_state = i2c_mbe_pkg::BS_START;
  logic [7:0]              shreg = 8'h00;
  logic [3:0]              bit_cnt = 4'd0;
  logic [7:0]              addr_reg = 8'h00;
  logic [15:0]             remaining = 16'd0;
  i2c_mbe_pkg::status_t    sts = i2c_mbe_pkg::STS_OK;
  bit                      busy = 1'b0;
  bit                      scl_lvl = 1'b1;
  bit                      sda_lvl = 1'b1;
  logic [7:0]              tx_fifo [i2c_mbe_pkg::TX_DEPTH_DEF];
  logic [7:0]              rx_fifo [i2c_mbe_pkg::RX_DEPTH_DEF];
  int                      tx_head = 0, tx_count = 0, rx_head = 0, rx_count = 0;

  i2c_mbe_pkg::out_item_t  expected_line_status [$];
  int                      mismatch_count = 0;
  int                      results_seen = 0;
  int                      requests_issued = 0;

  // Idling and receiver hold-off control
  bit idle_en = 1'b1;
  bit hold_kick = 1'b0;
  bit hold_kick_seen = 1'b0;
  int hold_len = 60;
  int hold_left = 0;
  int stall_left = 0;

  // Advance the predicted engine by one request and return its result
  function automatic i2c_mbe_pkg::out_item_t predict_bus_result(
      i2c_mbe_pkg::req_t req, logic sda, logic [7:0] data, logic [7:0] arw,
      logic [15:0] cnt);
    i2c_mbe_pkg::out_item_t res;
    res = '0;
    case (req)
      i2c_mbe_pkg::REQ_TICK: if (busy) begin
        if (!clk_phase) begin
          // rising SCL: start, ack sample, data sample, stop
          clk_phase = 1'b1;
          scl_lvl = 1'b1;
          case (seq_state)
            i2c_mbe_pkg::BS_START: begin
              sda_lvl = 1'b0;
              shreg = addr_reg;
              seq_state = i2c_mbe_pkg::BS_DOUT;
              bit_cnt = 4'd0;
            end
            i2c_mbe_pkg::BS_DOUT: if (bit_cnt == i2c_mbe_pkg::BITS_PER_BYTE) begin
              bit_cnt = 4'd0;
              shreg = 8'h00;
              seq_state = i2c_mbe_pkg::BS_RACK;
            end
            i2c_mbe_pkg::BS_RACK: if (!sda) begin
              if (addr_reg[0]) begin
                seq_state = i2c_mbe_pkg::BS_DIN;
              end else if (tx_count != 0) begin
                seq_state = i2c_mbe_pkg::BS_DOUT;
                shreg = tx_fifo[tx_head];
                tx_head = (tx_head + 1) % i2c_mbe_pkg::TX_DEPTH_DEF;
                tx_count--;
              end else begin
                seq_state = i2c_mbe_pkg::BS_STOP;
              end
            end else begin
              seq_state = i2c_mbe_pkg::BS_STOP;
              sts = i2c_mbe_pkg::STS_ERR;
            end
            i2c_mbe_pkg::BS_DIN: begin
              shreg = {shreg[6:0], sda};
              bit_cnt++;
              if (bit_cnt == i2c_mbe_pkg::BITS_PER_BYTE) begin
                bit_cnt = 4'd0;
                // full RX queue drops the byte
                if (rx_count < i2c_mbe_pkg::RX_DEPTH_DEF) begin
                  rx_fifo[(rx_head + rx_count) % i2c_mbe_pkg::RX_DEPTH_DEF] = shreg;
                  rx_count++;
                end
                shreg = 8'h00;
                if (remaining != 0) remaining--;
                seq_state = (remaining == 0) ? i2c_mbe_pkg::BS_STOP : i2c_mbe_pkg::BS_GACK;
              end
            end
            i2c_mbe_pkg::BS_GACK: seq_state = i2c_mbe_pkg::BS_DIN;
            i2c_mbe_pkg::BS_STOP: begin
              sda_lvl = 1'b1;
              busy = 1'b0;
              seq_state = i2c_mbe_pkg::BS_START;
              clk_phase = 1'b0;
              if (sts != i2c_mbe_pkg::STS_ERR) sts = i2c_mbe_pkg::STS_OK;
              res.done_res = 1'b1;
            end
            default: ;
          endcase
        end else begin
          // falling SCL: drive SDA
          clk_phase = 1'b0;
          scl_lvl = 1'b0;
          case (seq_state) inside
            i2c_mbe_pkg::BS_DOUT: begin
              sda_lvl = shreg[7];
              shreg = shreg << 1;
              bit_cnt++;
            end
            i2c_mbe_pkg::BS_RACK, i2c_mbe_pkg::BS_DIN: sda_lvl = 1'b1;
            i2c_mbe_pkg::BS_GACK, i2c_mbe_pkg::BS_STOP: sda_lvl = 1'b0;
            default: ;
          endcase
        end
      end
      i2c_mbe_pkg::REQ_PUSH: if (tx_count < i2c_mbe_pkg::TX_DEPTH_DEF) begin
        tx_fifo[(tx_head + tx_count) % i2c_mbe_pkg::TX_DEPTH_DEF] = data;
        tx_count++;
      end
      i2c_mbe_pkg::REQ_START: if (!busy) begin
        addr_reg = arw;
        remaining = (cnt == 16'd0) ? 16'd1 : cnt;
        bit_cnt = 4'd0;
        shreg = 8'h00;
        seq_state = i2c_mbe_pkg::BS_START;
        sts = i2c_mbe_pkg::STS_BUSY;
        busy = 1'b1;
      end
      i2c_mbe_pkg::REQ_POP: if (rx_count != 0) begin
        res.rx_byte = rx_fifo[rx_head];
        res.rx_valid = 1'b1;
        rx_head = (rx_head + 1) % i2c_mbe_pkg::RX_DEPTH_DEF;
        rx_count--;
      end
      default: ;
    endcase
    res.scl_out = scl_lvl;
    res.sda_out = sda_lvl;
    res.busy_res = busy;
    res.status = sts;
    res.rx_level = rx_count[i2c_mbe_pkg::RX_LEVEL_W-1:0];
    return res;
  endfunction

  // Offer one request, wait for acceptance, then maybe pause
  task automatic issue_request(input i2c_mbe_pkg::req_t req, input logic sda,
                               input logic [7:0] data, input logic [7:0] arw,
                               input logic [15:0] cnt);
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {7'd0, cnt, arw, data, sda};
    do @(posedge clk); while (!in_tready);
    expected_line_status.push_back(predict_bus_result(req, sda, data, arw, cnt));
    requests_issued++;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Unused fields always carry random values
  task automatic issue_tick(input logic sda);
    issue_request(i2c_mbe_pkg::REQ_TICK, sda, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic issue_push(input logic [7:0] data);
    issue_request(i2c_mbe_pkg::REQ_PUSH, 1'($urandom_range(0, 1)), data,
                  8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic issue_pop();
    issue_request(i2c_mbe_pkg::REQ_POP, 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)));
  endtask

  task automatic issue_start(input logic [7:0] arw, input logic [15:0] cnt);
    issue_request(i2c_mbe_pkg::REQ_START, 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), arw, cnt);
  endtask

  // Random tick, push or pop request; a start only when allowed
  task automatic issue_noise(input bit allow_start);
    int pick;
    pick = $urandom_range(0, allow_start ? 3 : 2);
    if (pick == 0) issue_tick(1'($urandom_range(0, 1)));
    else if (pick == 1) issue_push(8'($urandom_range(0, 255)));
    else if (pick == 2) issue_pop();
    else issue_start(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
  endtask

  // One bus transaction: start (and a second start if asked), then ticks and some noise until the stop completes
  task automatic run_transfer(input logic [7:0] arw, input logic [15:0] cnt,
                              input bit nack_addr, input int nack_pct,
                              input int noise_pct, input bit restart);
    bit   addr_phase;
    bit   ack_slot;
    logic sda;
    addr_phase = 1'b1;
    issue_start(arw, cnt);
    if (restart) issue_start(~arw, ~cnt);
    while (busy) begin
      // ack sample happens on the next rising SCL in the ack state; no noise there
      ack_slot = (seq_state == i2c_mbe_pkg::BS_RACK) && !clk_phase;
      if (!ack_slot && $urandom_range(0, 99) < noise_pct) begin
        issue_noise(1'b1);
      end else begin
        if (ack_slot) begin
          sda = addr_phase ? nack_addr : ($urandom_range(0, 99) < nack_pct);
          addr_phase = 1'b0;
        end else begin
          sda = 1'($urandom_range(0, 1));
        end
        issue_tick(sda);
      end
    end
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (expected_line_status.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_kick != hold_kick_seen) begin
      hold_kick_seen <= hold_kick;
      hold_left <= hold_len;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    i2c_mbe_pkg::out_item_t got;
    i2c_mbe_pkg::out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = i2c_mbe_pkg::out_item_t'(out_tdata);
      results_seen++;
      if (expected_line_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with nothing expected: %h", results_seen, out_tdata);
      end else begin
        want = expected_line_status.pop_front();
        if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
            got.busy_res !== want.busy_res || got.status !== want.status ||
            got.done_res !== want.done_res || got.rx_byte !== want.rx_byte ||
            got.rx_valid !== want.rx_valid || got.rx_level !== want.rx_level) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result %0d: expected scl=%0b sda=%0b busy=%0b status=%0d done=%0b",
                     results_seen, want.scl_out, want.sda_out, want.busy_res, want.status,
                     want.done_res);
            $display("  rx_byte=%02h rx_valid=%0b rx_level=%0d", want.rx_byte,
                     want.rx_valid, want.rx_level);
            $display("  got scl=%0b sda=%0b busy=%0b status=%0d done=%0b", got.scl_out,
                     got.sda_out, got.busy_res, got.status, got.done_res);
            $display("  rx_byte=%02h rx_valid=%0b rx_level=%0d", got.rx_byte,
                     got.rx_valid, got.rx_level);
          end
        end
      end
    end
  end

  // Idle-bus requests: tick while idle, empty pop, extreme pushes
  task automatic test_idle_requests();
    issue_tick(1'b0);
    issue_tick(1'b1);
    issue_pop();
    issue_push(8'h00);
    issue_push(8'hFF);
    issue_pop();
  endtask

  // Address NACK on a maximal read, with a start while active
  task automatic test_address_nack();
    run_transfer(8'hFF, 16'hFFFF, 1'b1, 0, 0, 1'b1);
  endtask

  // Writes: queued bytes to address zero, then an empty TX queue
  task automatic test_write_paths();
    run_transfer(8'h00, 16'h0000, 1'b0, 0, 0, 1'b0);
    run_transfer(8'hA4, 16'($urandom_range(0, 65535)), 1'b0, 0, 0, 1'b0);
  endtask

  // Push past TX depth, then drain it on the bus
  task automatic test_tx_overflow();
    repeat (i2c_mbe_pkg::TX_DEPTH_DEF + 2) issue_push(8'($urandom_range(0, 255)));
    run_transfer(8'h5A, 16'd0, 1'b0, 0, 0, 1'b0);
  endtask

  // NACK on a data byte leaves bytes queued for the next write
  task automatic test_data_nack();
    repeat (3) issue_push(8'($urandom_range(0, 255)));
    run_transfer(8'h3C, 16'd5, 1'b0, 100, 0, 1'b0);
    run_transfer(8'h3C, 16'd5, 1'b0, 0, 0, 1'b0);
  endtask

  // Zero count reads one byte
  task automatic test_read_zero_count();
    run_transfer(8'hA1, 16'd0, 1'b0, 0, 0, 1'b0);
    issue_pop();
    issue_pop();
  endtask

  // Read more than RX depth without popping, then empty the queue
  task automatic test_rx_overflow();
    run_transfer(8'hA1, 16'd18, 1'b0, 0, 0, 1'b0);
    repeat (i2c_mbe_pkg::RX_DEPTH_DEF + 1) issue_pop();
  endtask

  // Long receiver hold-off while requests keep coming, then a full drain
  task automatic test_stall_pressure();
    idle_en <= 1'b0;
    hold_kick <= ~hold_kick;
    run_transfer(8'h91, 16'd2, 1'b0, 0, 0, 1'b0);
    repeat (rx_count) issue_pop();
    wait_results_drained();
    idle_en <= 1'b1;
  endtask

  // Mostly well-formed transactions with random content, some noise
  task automatic test_random_traffic();
    int          target;
    int          pick;
    logic [6:0]  addr7;
    logic [15:0] cnt;
    target = requests_issued + 700;
    while (requests_issued < target) begin
      pick = $urandom_range(0, 99);
      addr7 = 7'($urandom_range(0, 127));
      if (pick < 40) begin
        repeat ($urandom_range(0, 4)) issue_push(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) repeat (14) issue_push(8'($urandom_range(0, 255)));
        run_transfer({addr7, 1'b0}, 16'($urandom_range(0, 65535)),
                     $urandom_range(0, 9) == 0, 8, 4, 1'b0);
      end else if (pick < 75) begin
        cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 20))
                                          : 16'($urandom_range(0, 6));
        run_transfer({addr7, 1'b1}, cnt, $urandom_range(0, 9) == 0, 0, 4, 1'b0);
        repeat ($urandom_range(0, rx_count + 1)) issue_pop();
      end else if (pick < 85) begin
        // large counts only with an address NACK to keep reads short
        run_transfer({addr7, 1'b1}, 16'($urandom_range(0, 65535)), 1'b1, 0, 4,
                     1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 6)) issue_noise(1'b0);
      end
    end
  endtask

  // Closing traffic at full rate on both sides
  task automatic test_full_rate();
    idle_en <= 1'b0;
    repeat (2) issue_push(8'($urandom_range(0, 255)));
    run_transfer(8'h50, 16'd0, 1'b0, 0, 0, 1'b0);
    run_transfer(8'h51, 16'd3, 1'b0, 0, 0, 1'b0);
    repeat (rx_count + 1) issue_pop();
  endtask

  // Run limit
  initial begin
    #10_000_000;
    $display("i2c_master_bit_engine: mismatch");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_requests();
    test_address_nack();
    test_write_paths();
    test_tx_overflow();
    test_data_nack();
    test_read_zero_count();
    test_rx_overflow();
    test_stall_pressure();
    test_random_traffic();
    test_full_rate();
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_line_status.size() == 0) begin
      $display("i2c_master_bit_engine: match");
    end else begin
      $display("i2c_master_bit_engine: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/i2c_mbe_pkg.sv
hdl/i2c_master_bit_engine.sv
tb/tb.sv
